/* hdl/gcr_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, register codes and records for the grid cell enumeration block.
package gcr_pkg;

  localparam int COORD_W    = 16;  // rectangle edge, signed
  localparam int SIZE_W     = 15;  // rectangle extent, unsigned
  localparam int CELL_W     = 13;  // cell width / height
  localparam int COLS_W     = 11;  // grid columns
  localparam int LEVEL_W    = 15;  // level bounds
  localparam int INDEX_W    = 20;  // cell index
  localparam int NUM_W      = 17;  // edge plus extent, signed
  localparam int QUOT_W     = 18;  // signed cell coordinate
  localparam int PIX_W      = 32;  // signed corner position in pixels
  localparam int SPAN_W     = 3;   // cell offset within a clipped span
  localparam int DIV_STEPS  = 17;  // one quotient bit per step
  localparam int DIV_CNT_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_WIDTH   = 3'd0,
    REG_CELL_HEIGHT  = 3'd1,
    REG_COLUMNS      = 3'd2,
    REG_LEVEL_WIDTH  = 3'd3,
    REG_LEVEL_HEIGHT = 3'd4
  } cfg_reg_t;

  // Grid settings as seen by the datapath; cell sizes already forced nonzero.
  typedef struct packed {
    logic [CELL_W-1:0]  cell_w;
    logic [CELL_W-1:0]  cell_h;
    logic [COLS_W-1:0]  cols;
    logic [LEVEL_W-1:0] level_w;
    logic [LEVEL_W-1:0] level_h;
  } gcr_cfg_t;

  // One classified rectangle, ready for the cell walk.
  typedef struct packed {
    logic signed [PIX_W-1:0] px0;       // left corner of first column
    logic signed [PIX_W-1:0] py0;       // top corner of first row
    logic [INDEX_W-1:0]      base_idx;  // index of first cell, wrapped
    logic [SPAN_W-1:0]       nx;        // last column offset
    logic [SPAN_W-1:0]       ny;        // last row offset
    logic                    clipped;
  } gcr_job_t;

endpackage

/* hdl/gcr_if.sv */
`timescale 1ns / 1ps
// Valid/ready channels for rectangles in and cell indexes out.
interface gcr_rect_if import gcr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] rect_x;
  logic signed [COORD_W-1:0] rect_y;
  logic [SIZE_W-1:0]         rect_w;
  logic [SIZE_W-1:0]         rect_h;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface gcr_cell_if import gcr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] cell_index;
  logic               last_cell;
  logic               span_clipped;

  modport source (output valid, cell_index, last_cell, span_clipped, input ready);
  modport sink   (input valid, cell_index, last_cell, span_clipped, output ready);
endinterface

/* hdl/gcr_div.sv */
`timescale 1ns / 1ps
// Restoring divider: signed numerator by positive cell size, truncating toward zero.
module gcr_div import gcr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [NUM_W-1:0]  num,
  input  logic [CELL_W-1:0]        den,
  output logic                     done,
  output logic signed [QUOT_W-1:0] quot
);

  logic                 busy_r, done_r, neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CELL_W-1:0]    den_r, rem_r;
  logic [NUM_W-1:0]     acc_r;
  logic [NUM_W-1:0]     mag;
  logic [CELL_W:0]      trial;
  logic                 ge;

  assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign trial = {rem_r, acc_r[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
        den_r  <= den;
        rem_r  <= '0;
        acc_r  <= mag;
        neg_r  <= num[NUM_W-1];
      end else if (busy_r) begin
        // shift in one numerator bit, keep one quotient bit
        rem_r <= ge ? CELL_W'(trial - {1'b0, den_r}) : trial[CELL_W-1:0];
        acc_r <= {acc_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});

endmodule

/* hdl/gcr_front.sv */
`timescale 1ns / 1ps
// Front end: takes a rectangle, divides its edges into cells, clips the span.
module gcr_front import gcr_pkg::*; #(
  parameter int MAX_SPAN = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gcr_cfg_t        cfg,
  gcr_rect_if.sink        in_rect,
  output logic            push,
  output gcr_job_t        push_job,
  input  logic            full
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_MUL, F_PUSH} front_state_t;

  front_state_t state_r;
  gcr_job_t     job_r;
  logic         accept;
  logic [3:0]   div_done;
  logic signed [NUM_W-1:0]  n_x0, n_x1, n_y0, n_y1;
  logic signed [QUOT_W-1:0] q_x0, q_x1, q_y0, q_y1;
  logic [QUOT_W:0]          span_x, span_y;
  logic                     clip_x, clip_y;
  logic signed [PIX_W-1:0]  px0, py0;
  logic [INDEX_W-1:0]       row_prod;

  assign in_rect.ready = (state_r == F_IDLE);
  assign accept        = in_rect.valid && in_rect.ready;

  assign n_x0 = NUM_W'(in_rect.rect_x);
  assign n_y0 = NUM_W'(in_rect.rect_y);
  assign n_x1 = n_x0 + $signed({2'b0, in_rect.rect_w});
  assign n_y1 = n_y0 + $signed({2'b0, in_rect.rect_h});

  gcr_div u_div_x0 (.clk, .rst_n, .start(accept), .num(n_x0), .den(cfg.cell_w),
                    .done(div_done[0]), .quot(q_x0));
  gcr_div u_div_x1 (.clk, .rst_n, .start(accept), .num(n_x1), .den(cfg.cell_w),
                    .done(div_done[1]), .quot(q_x1));
  gcr_div u_div_y0 (.clk, .rst_n, .start(accept), .num(n_y0), .den(cfg.cell_h),
                    .done(div_done[2]), .quot(q_y0));
  gcr_div u_div_y1 (.clk, .rst_n, .start(accept), .num(n_y1), .den(cfg.cell_h),
                    .done(div_done[3]), .quot(q_y1));

  // span minus one per axis; never negative since truncation is monotonic
  assign span_x = {q_x1[QUOT_W-1], q_x1} - {q_x0[QUOT_W-1], q_x0};
  assign span_y = {q_y1[QUOT_W-1], q_y1} - {q_y0[QUOT_W-1], q_y0};
  assign clip_x = (span_x >= (QUOT_W+1)'(MAX_SPAN));
  assign clip_y = (span_y >= (QUOT_W+1)'(MAX_SPAN));

  assign px0 = $signed({{(PIX_W-QUOT_W){q_x0[QUOT_W-1]}}, q_x0})
             * $signed({{(PIX_W-CELL_W){1'b0}}, cfg.cell_w});
  assign py0 = $signed({{(PIX_W-QUOT_W){q_y0[QUOT_W-1]}}, q_y0})
             * $signed({{(PIX_W-CELL_W){1'b0}}, cfg.cell_h});
  // index arithmetic wraps at the index width, so low bits suffice
  assign row_prod = {{(INDEX_W-QUOT_W){q_y0[QUOT_W-1]}}, q_y0}
                  * {{(INDEX_W-COLS_W){1'b0}}, cfg.cols};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) state_r <= F_DIV;
        end
        F_DIV: begin
          if (div_done[0]) state_r <= F_MUL;
        end
        F_MUL: begin
          job_r.px0      <= px0;
          job_r.py0      <= py0;
          job_r.base_idx <= row_prod + {{(INDEX_W-QUOT_W){q_x0[QUOT_W-1]}}, q_x0};
          job_r.nx       <= clip_x ? SPAN_W'(MAX_SPAN - 1) : span_x[SPAN_W-1:0];
          job_r.ny       <= clip_y ? SPAN_W'(MAX_SPAN - 1) : span_y[SPAN_W-1:0];
          job_r.clipped  <= clip_x || clip_y;
          state_r        <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign push     = (state_r == F_PUSH) && !full;
  assign push_job = job_r;

  a_div_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (div_done != 4'b0) |-> (div_done == 4'b1111))
    else $error("dividers finished out of step");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done[0] |-> (state_r == F_DIV))
    else $error("division finished outside the divide state");

endmodule

/* hdl/gcr_queue.sv */
`timescale 1ns / 1ps
// Short queue of classified rectangles between front end and cell walker.
module gcr_queue import gcr_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  gcr_job_t push_job,
  output logic     full,
  input  logic     pop,
  output gcr_job_t pop_job,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gcr_job_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue pushed while full or popped while empty");

endmodule

/* hdl/gcr_back.sv */
`timescale 1ns / 1ps
// Cell walker: steps over the clipped span, drops cells outside the level, emits indexes.
module gcr_back import gcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  gcr_cfg_t  cfg,
  input  logic      empty,
  input  gcr_job_t  pop_job,
  output logic      pop,
  gcr_cell_if.source out_cell
);

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_FLUSH} back_state_t;

  back_state_t             state_r;
  logic signed [PIX_W-1:0] px_r, py_r, px0_r;
  logic [INDEX_W-1:0]      idx_r, row_idx_r;
  logic [SPAN_W-1:0]       cx_r, cy_r, nx_r, ny_r;
  logic                    clip_r;
  logic                    hold_valid_r;
  logic [INDEX_W-1:0]      hold_idx_r;
  logic                    out_valid_r, out_last_r, out_clip_r;
  logic [INDEX_W-1:0]      out_idx_r;
  logic                    cell_ok, out_free, stall;
  logic [INDEX_W-1:0]      next_row_idx;

  assign pop = (state_r == B_IDLE) && !empty;

  assign cell_ok = !px_r[PIX_W-1] && !py_r[PIX_W-1]
                && (px_r <= $signed({{(PIX_W-LEVEL_W){1'b0}}, cfg.level_w}))
                && (py_r <= $signed({{(PIX_W-LEVEL_W){1'b0}}, cfg.level_h}));
  assign out_free     = !out_valid_r || out_cell.ready;
  // a second in-bounds cell needs the held one to leave first
  assign stall        = cell_ok && hold_valid_r && !out_free;
  assign next_row_idx = row_idx_r + {{(INDEX_W-COLS_W){1'b0}}, cfg.cols};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_cell.ready) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!empty) begin
            px_r      <= pop_job.px0;
            px0_r     <= pop_job.px0;
            py_r      <= pop_job.py0;
            idx_r     <= pop_job.base_idx;
            row_idx_r <= pop_job.base_idx;
            nx_r      <= pop_job.nx;
            ny_r      <= pop_job.ny;
            clip_r    <= pop_job.clipped;
            cx_r      <= '0;
            cy_r      <= '0;
            state_r   <= B_SCAN;
          end
        end
        B_SCAN: begin
          if (!stall) begin
            if (cell_ok) begin
              hold_idx_r   <= idx_r;
              hold_valid_r <= 1'b1;
              if (hold_valid_r) begin
                out_valid_r <= 1'b1;
                out_idx_r   <= hold_idx_r;
                out_last_r  <= 1'b0;
                out_clip_r  <= clip_r;
              end
            end
            // advance row-major
            if (cx_r == nx_r) begin
              if (cy_r == ny_r) begin
                state_r <= B_FLUSH;
              end else begin
                cx_r      <= '0;
                cy_r      <= cy_r + 1'b1;
                px_r      <= px0_r;
                py_r      <= py_r + $signed({{(PIX_W-CELL_W){1'b0}}, cfg.cell_h});
                row_idx_r <= next_row_idx;
                idx_r     <= next_row_idx;
              end
            end else begin
              cx_r  <= cx_r + 1'b1;
              px_r  <= px_r + $signed({{(PIX_W-CELL_W){1'b0}}, cfg.cell_w});
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        B_FLUSH: begin
          if (!hold_valid_r) begin
            state_r <= B_IDLE;
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            out_idx_r    <= hold_idx_r;
            out_last_r   <= 1'b1;
            out_clip_r   <= clip_r;
            hold_valid_r <= 1'b0;
            state_r      <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_cell.valid        = out_valid_r;
  assign out_cell.cell_index   = out_idx_r;
  assign out_cell.last_cell    = out_last_r;
  assign out_cell.span_clipped = out_clip_r;

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_IDLE) |-> !hold_valid_r)
    else $error("held cell left over from previous rectangle");

  a_scan_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SCAN) |-> (cx_r <= nx_r) && (cy_r <= ny_r))
    else $error("cell walk ran past the clipped span");

endmodule

/* hdl/grid_cells_for_rectangle_unit.sv */
`timescale 1ns / 1ps
// Top level: configuration registers, front end, job queue and cell walker.
//
//   channel   dir  handshake          payload
//   in_rect   in   valid/ready        rect_x, rect_y, rect_w, rect_h
//   out_cell  out  valid/ready        cell_index, last_cell, span_clipped
//   cfg_*     in   cfg_we             cfg_index, cfg_data
//
// Front end: accept, divide (17 steps of four bit-serial dividers in parallel,
// then the done flag), multiply, queue push; a new rectangle is taken only once
// the last is pushed, and the push stretches while the queue is full.
// Walker: load, one cell of the clipped span (up to 64) per cycle unless an
// output stall holds it, then flush; cells outside the level are still visited.
// Synchronous active-low reset; no clearing pass; grid registers get defaults.
// Output stalls hold the walker when a second in-bounds cell is ready or when
// the last cell waits in the flush state.
module grid_cells_for_rectangle_unit import gcr_pkg::*; #(
  parameter int MAX_SPAN    = 8,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gcr_rect_if.sink              in_rect,
  gcr_cell_if.source            out_cell,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CELL_W-1:0]  cell_w_r, cell_h_r;
  logic [COLS_W-1:0]  cols_r;
  logic [LEVEL_W-1:0] level_w_r, level_h_r;
  gcr_cfg_t           cfg;
  logic               push, pop, full, empty;
  gcr_job_t           push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_w_r  <= CELL_W'(32);
      cell_h_r  <= CELL_W'(32);
      cols_r    <= COLS_W'(32);
      level_w_r <= LEVEL_W'(1023);
      level_h_r <= LEVEL_W'(1023);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_WIDTH:   cell_w_r  <= cfg_data[CELL_W-1:0];
        REG_CELL_HEIGHT:  cell_h_r  <= cfg_data[CELL_W-1:0];
        REG_COLUMNS:      cols_r    <= cfg_data[COLS_W-1:0];
        REG_LEVEL_WIDTH:  level_w_r <= cfg_data[LEVEL_W-1:0];
        REG_LEVEL_HEIGHT: level_h_r <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero cell size behaves as one pixel
  assign cfg.cell_w  = (cell_w_r == '0) ? CELL_W'(1) : cell_w_r;
  assign cfg.cell_h  = (cell_h_r == '0) ? CELL_W'(1) : cell_h_r;
  assign cfg.cols    = cols_r;
  assign cfg.level_w = level_w_r;
  assign cfg.level_h = level_h_r;

  gcr_front #(.MAX_SPAN(MAX_SPAN)) u_front (
    .clk, .rst_n, .cfg, .in_rect, .push, .push_job, .full
  );

  gcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push, .push_job, .full, .pop, .pop_job, .empty
  );

  gcr_back u_back (
    .clk, .rst_n, .cfg, .empty, .pop_job, .pop, .out_cell
  );

endmodule

/* tb/grid_cells_for_rectangle_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the grid cell enumeration unit: directed and random rectangles.
module grid_cells_for_rectangle_unit_test;
  import gcr_pkg::*;

  localparam int MAX_SPAN       = 8;
  localparam int RESET_CYCLES   = 7;
  localparam int QUIET_CYCLES   = 400;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } rect_t;

  typedef struct {
    logic [INDEX_W-1:0] cell_index;
    logic               last_cell;
    logic               span_clipped;
  } cell_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gcr_rect_if rect_ch ();
  gcr_cell_if cell_ch ();

  grid_cells_for_rectangle_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_rect  (rect_ch),
    .out_cell (cell_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Local copy of the grid registers
  logic [CELL_W-1:0]  grid_cell_w  = 13'd32;
  logic [CELL_W-1:0]  grid_cell_h  = 13'd32;
  logic [COLS_W-1:0]  grid_cols    = 11'd32;
  logic [LEVEL_W-1:0] grid_level_w = 15'd1023;
  logic [LEVEL_W-1:0] grid_level_h = 15'd1023;

  rect_t rect_queue[$];
  cell_t cells_expected[$];
  int    rects_pushed   = 0;
  int    rects_accepted = 0;
  int    sender_idle_pct = 0;
  int    recv_stall_pct  = 0;
  bit    hold_armed  = 1'b0;
  bit    hold_used;
  int    hold_cnt;
  bit    any_failure = 1'b0;
  int    idle_cycles = 0;
  rect_t offered;

  function automatic void enumerate_cells(input rect_t r);
    longint cw, ch, x0, x1, y0, y1, cx, cy, idx;
    logic   clip;
    cell_t  c;
    cell_t  run[$];
    cw = (grid_cell_w == '0) ? 1 : longint'(grid_cell_w);
    ch = (grid_cell_h == '0) ? 1 : longint'(grid_cell_h);
    x0 = longint'(r.x) / cw;
    x1 = (longint'(r.x) + longint'(r.w)) / cw;
    y0 = longint'(r.y) / ch;
    y1 = (longint'(r.y) + longint'(r.h)) / ch;
    clip = 1'b0;
    if (x1 - x0 + 1 > MAX_SPAN) begin
      x1 = x0 + MAX_SPAN - 1;
      clip = 1'b1;
    end
    if (y1 - y0 + 1 > MAX_SPAN) begin
      y1 = y0 + MAX_SPAN - 1;
      clip = 1'b1;
    end
    for (cy = y0; cy <= y1; cy++) begin
      for (cx = x0; cx <= x1; cx++) begin
        // drop cells whose top-left corner lies outside the level
        if (cx * cw < 0 || cy * ch < 0 || cx * cw > longint'(grid_level_w) ||
            cy * ch > longint'(grid_level_h))
          continue;
        idx = cy * longint'(grid_cols) + cx;
        c.cell_index   = idx[INDEX_W-1:0];
        c.last_cell    = 1'b0;
        c.span_clipped = clip;
        run.insert(run.size(), c);
      end
    end
    if (run.size() != 0) run[run.size()-1].last_cell = 1'b1;
    foreach (run[i]) cells_expected.insert(cells_expected.size(), run[i]);
  endfunction

  function automatic int clip_to(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic rect_t rand_rect();
    rect_t r;
    int    cw, ch, v;
    cw = (grid_cell_w == '0) ? 1 : int'(grid_cell_w);
    ch = (grid_cell_h == '0) ? 1 : int'(grid_cell_h);
    if ($urandom_range(99) < 20) begin
      r.x = COORD_W'($urandom);
      r.y = COORD_W'($urandom);
      r.w = SIZE_W'($urandom);
      r.h = SIZE_W'($urandom);
    end else begin
      // aim near the level so most rectangles produce cells
      v = int'($urandom_range(0, int'(grid_level_w) + 2 * cw)) - cw;
      r.x = COORD_W'(clip_to(v, -32768, 32767));
      v = int'($urandom_range(0, int'(grid_level_h) + 2 * ch)) - ch;
      r.y = COORD_W'(clip_to(v, -32768, 32767));
      if ($urandom_range(9) == 0) begin
        r.w = SIZE_W'(clip_to(int'($urandom_range(0, cw * 10)), 0, 32767));
        r.h = SIZE_W'(clip_to(int'($urandom_range(0, ch * 10)), 0, 32767));
      end else begin
        r.w = SIZE_W'(clip_to(int'($urandom_range(0, cw * 3)), 0, 32767));
        r.h = SIZE_W'(clip_to(int'($urandom_range(0, ch * 3)), 0, 32767));
      end
    end
    return r;
  endfunction

  task automatic push_rect(input int x, input int y, input int w, input int h);
    rect_t r;
    r.x = COORD_W'(x);
    r.y = COORD_W'(y);
    r.w = SIZE_W'(w);
    r.h = SIZE_W'(h);
    rect_queue.insert(rect_queue.size(), r);
    rects_pushed++;
  endtask

  task automatic push_random(input int count);
    repeat (count) begin
      rect_queue.insert(rect_queue.size(), rand_rect());
      rects_pushed++;
    end
  endtask

  task automatic program_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_CELL_WIDTH:   grid_cell_w  = val[CELL_W-1:0];
      REG_CELL_HEIGHT:  grid_cell_h  = val[CELL_W-1:0];
      REG_COLUMNS:      grid_cols    = val[COLS_W-1:0];
      REG_LEVEL_WIDTH:  grid_level_w = val[LEVEL_W-1:0];
      REG_LEVEL_HEIGHT: grid_level_h = val[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [CFG_DATA_W-1:0] cw, input logic [CFG_DATA_W-1:0] ch,
                          input logic [CFG_DATA_W-1:0] cols,
                          input logic [CFG_DATA_W-1:0] lw, input logic [CFG_DATA_W-1:0] lh);
    program_reg(REG_CELL_WIDTH, cw);
    program_reg(REG_CELL_HEIGHT, ch);
    program_reg(REG_COLUMNS, cols);
    program_reg(REG_LEVEL_WIDTH, lw);
    program_reg(REG_LEVEL_HEIGHT, lh);
    cfg_we <= 1'b0;
  endtask

  // Wait until every rectangle is taken and every cell is back, then let the tail settle
  task automatic drain();
    while (rects_accepted != rects_pushed || cells_expected.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Rectangle driver
  always @(posedge clk) begin
    if (!rst_n) begin
      rect_ch.valid <= 1'b0;
    end else begin
      if (rect_ch.valid && rect_ch.ready) begin
        enumerate_cells(offered);
        rects_accepted++;
      end
      if (!rect_ch.valid || rect_ch.ready) begin
        if (rect_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered = rect_queue.pop_front();
          rect_ch.valid  <= 1'b1;
          rect_ch.rect_x <= offered.x;
          rect_ch.rect_y <= offered.y;
          rect_ch.rect_w <= offered.w;
          rect_ch.rect_h <= offered.h;
        end else begin
          rect_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Cell monitor and receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      cell_ch.ready <= 1'b0;
      hold_used     <= 1'b0;
      hold_cnt      <= 0;
    end else begin
      if (cell_ch.valid && cell_ch.ready) begin
        if (cells_expected.size() == 0) begin
          $error("unexpected cell transaction: cell_index %0d", cell_ch.cell_index);
          any_failure = 1'b1;
        end else begin
          cell_t exp_cell;
          exp_cell = cells_expected.pop_front();
          if (cell_ch.cell_index !== exp_cell.cell_index) begin
            $error("cell_index: expected %0d, actual %0d",
                   exp_cell.cell_index, cell_ch.cell_index);
            any_failure = 1'b1;
          end
          if (cell_ch.last_cell !== exp_cell.last_cell) begin
            $error("last_cell: expected %0b, actual %0b",
                   exp_cell.last_cell, cell_ch.last_cell);
            any_failure = 1'b1;
          end
          if (cell_ch.span_clipped !== exp_cell.span_clipped) begin
            $error("span_clipped: expected %0b, actual %0b",
                   exp_cell.span_clipped, cell_ch.span_clipped);
            any_failure = 1'b1;
          end
        end
      end
      if (hold_armed && !hold_used) begin
        hold_used     <= 1'b1;
        hold_cnt      <= LONG_HOLD;
        cell_ch.ready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt      <= hold_cnt - 1;
        cell_ch.ready <= 1'b0;
      end else begin
        cell_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((rect_ch.valid && rect_ch.ready) || (cell_ch.valid && cell_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    rect_ch.valid  = 1'b0;
    rect_ch.rect_x = '0;
    rect_ch.rect_y = '0;
    rect_ch.rect_w = '0;
    rect_ch.rect_h = '0;
    cell_ch.ready  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset grid: 32 pixel cells, 32 columns, level 0..1023
    push_rect(0, 0, 0, 0);
    push_rect(-32768, -32768, 0, 0);
    push_rect(32767, 32767, 32767, 32767);
    push_rect(-32768, -32768, 32767, 32767);
    push_rect(-5, -5, 10, 10);            // truncation toward zero on negative edges
    push_rect(0, 0, 300, 300);            // clipped on both axes
    push_rect(0, 0, 255, 0);              // exactly eight columns
    push_rect(1000, 1000, 100, 100);      // partly outside the level
    push_rect(-40, -40, 100, 100);
    push_rect(1023, 1023, 0, 0);
    push_rect(1024, 0, 0, 0);
    drain();

    // Zero cell sizes act as one; widest grid so indexes wrap
    set_grid(15'h6000, 15'h2000, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    push_rect(32767, 32767, 0, 0);
    push_rect(32767, 32767, 32767, 32767);
    push_rect(-3, -3, 5, 5);
    push_rect(0, 0, 7, 7);
    push_rect(0, 0, 8, 8);
    push_rect(-32768, 0, 32767, 0);
    push_rect(100, 200, 0, 7);
    push_rect(20000, 0, 0, 32767);
    push_random(20);
    drain();

    set_grid(15'd4096, 15'd4096, 15'd1, 15'd0, 15'd0);
    sender_idle_pct = 53;
    push_random(25);
    drain();

    set_grid(CFG_DATA_W'($urandom_range(1, 64)), CFG_DATA_W'($urandom_range(1, 64)),
             CFG_DATA_W'($urandom_range(1, 1024)),
             CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'($urandom_range(0, 2047)));
    sender_idle_pct = 0;
    recv_stall_pct  = 53;
    push_random(25);
    drain();

    // Over-wide write to the cell width keeps its low bits
    set_grid(15'h7FFF, 15'd1, 15'd1024, 15'd32767, 15'd32767);
    sender_idle_pct = 27;
    recv_stall_pct  = 27;
    push_random(25);
    drain();

    // Long receiver hold while rectangles keep coming
    set_grid(15'd8, 15'd8, 15'd128, 15'd1023, 15'd1023);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_armed      = 1'b1;
    push_random(25);
    drain();

    set_grid(15'd32, 15'd32, 15'd32, 15'd1023, 15'd1023);
    sender_idle_pct = 27;
    recv_stall_pct  = 27;
    push_random(30);
    drain();

    if (!any_failure && cells_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/gcr_pkg.sv
hdl/gcr_if.sv
hdl/gcr_div.sv
hdl/gcr_front.sv
hdl/gcr_queue.sv
hdl/gcr_back.sv
hdl/grid_cells_for_rectangle_unit.sv
tb/grid_cells_for_rectangle_unit_test.sv
